@@ rtl/gfs_pkg.sv @@
// ----------------------------------------------------------------------------
// GSAT flip selector package
// Shared widths, codes and types of the flip selector.
// ----------------------------------------------------------------------------
package gfs_pkg;

    localparam int MAX_VARIABLES     = 1024;
    localparam int MAX_CLAUSES       = 4096;
    localparam int MAX_CLAUSE_LENGTH = 8;

    localparam int VAR_W    = 10;   // variable number
    localparam int NV_W     = 11;   // variable count
    localparam int CIDX_W   = 12;   // clause number
    localparam int NC_W     = 13;   // clause count, also the step counter
    localparam int SLOT_W   = 3;
    localparam int LIT_W    = 12;
    localparam int ROW_W    = LIT_W * MAX_CLAUSE_LENGTH;
    localparam int GAIN_W   = 13;
    localparam int WALK_W   = 10;
    localparam int DRAW_W   = 32;
    localparam int DSTEP_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 13;

    // Literal layout inside a clause row.
    localparam int LIT_POL_BIT  = 10;
    localparam int LIT_USED_BIT = 11;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARIABLES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLAUSES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_THRESHOLD = 2'd2;

    localparam logic [NV_W-1:0]   NUM_VARIABLES_RST  = 11'd1;
    localparam logic [NC_W-1:0]   NUM_CLAUSES_RST    = 13'd0;
    localparam logic [WALK_W-1:0] WALK_THRESHOLD_RST = 10'd100;

    // Request to the remainder unit.
    typedef struct packed {
        logic              start;
        logic [DRAW_W-1:0] dividend;
        logic [NV_W-1:0]   divisor;
    } div_req_t;

endpackage

@@ rtl/gfs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/gfs_mod_unit.sv @@
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module gfs_mod_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gfs_pkg::div_req_t             req,
    output logic                          done,
    output logic [gfs_pkg::VAR_W-1:0]     rem
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [gfs_pkg::DSTEP_W-1:0]   step_reg;
    logic [gfs_pkg::DRAW_W-1:0]    quo_reg;
    logic [gfs_pkg::VAR_W-1:0]     rem_reg;
    logic [gfs_pkg::NV_W-1:0]      div_reg;
    logic [gfs_pkg::NV_W-1:0]      trial;
    logic [gfs_pkg::NV_W-1:0]      diff;

    assign trial = {rem_reg, quo_reg[gfs_pkg::DRAW_W-1]};
    assign diff  = trial - div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[gfs_pkg::DRAW_W-2:0], 1'b0};
            // The remainder stays below the divisor, so ten bits hold it.
            if (trial >= div_reg) begin
                rem_reg <= diff[gfs_pkg::VAR_W-1:0];
            end else begin
                rem_reg <= trial[gfs_pkg::VAR_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/gsat_flip_selector.sv @@
// ----------------------------------------------------------------------------
// GSAT flip selector
// One step of a GSAT-style local search over a clause store held in RAM.
// ----------------------------------------------------------------------------
// Usage. Every transfer on the s_axis channel yields exactly one transfer on
// the m_axis channel. s_axis_tuser carries the mode: a literal load writes one
// slot of a clause row, a value set writes one variable, a step flips one
// variable. A load, a value set or an unused mode returns an all-zero result.
// A step with a random walk divides the pick draw by the variable count
// and flips the variable the remainder names. A greedy step clears the gain
// table, walks the clause RAM and gives gain to each literal of an unsatisfied
// clause whose variable appears once in it, scans the gains, divides by the tie
// count and flips the chosen variable.
// Every step then checks the clauses again, stopping at the first unsatisfied
// one. The clause walks through the single read port of the assignment RAM
// set the rate. One item is in flight at a time.
// After reset a clearing pass zeroes the clause and assignment RAMs;
// s_axis_tready stays low meanwhile. Configuration writes are taken at
// any time. A result waits in the output register while m_axis_tready is low,
// and no new item is accepted until it has been transferred.
// ----------------------------------------------------------------------------
module gsat_flip_selector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [gfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gfs_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // clause_index, slot, variable, polarity, slot_used, walk_draw, pick_draw
    input  logic [71:0]                     s_axis_tdata,
    // mode
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // flipped_variable, best_gain, tie_count, all_satisfied
    output logic [39:0]                     m_axis_tdata,
    // random_walk
    output logic                            m_axis_tuser
);

    localparam logic [4:0] ST_CLEAR    = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_LD_WR    = 5'd2;
    localparam logic [4:0] ST_DIV_WAIT = 5'd3;
    localparam logic [4:0] ST_TIE_WAIT = 5'd4;
    localparam logic [4:0] ST_GCLR     = 5'd5;
    localparam logic [4:0] ST_ROW      = 5'd6;
    localparam logic [4:0] ST_ROWW     = 5'd7;
    localparam logic [4:0] ST_LIT      = 5'd8;
    localparam logic [4:0] ST_LIT_END  = 5'd9;
    localparam logic [4:0] ST_GRD      = 5'd10;
    localparam logic [4:0] ST_GWR      = 5'd11;
    localparam logic [4:0] ST_SCAN     = 5'd12;
    localparam logic [4:0] ST_SCAN_END = 5'd13;
    localparam logic [4:0] ST_TIE_DIV  = 5'd14;
    localparam logic [4:0] ST_FLIP_RD  = 5'd15;
    localparam logic [4:0] ST_FLIP_WR  = 5'd16;
    localparam logic [4:0] ST_DONE     = 5'd17;

    // Input fields.
    logic [gfs_pkg::CIDX_W-1:0] in_cidx;
    logic [gfs_pkg::SLOT_W-1:0] in_slot;
    logic [gfs_pkg::VAR_W-1:0]  in_var;
    logic                       in_pol;
    logic                       in_used;
    logic [gfs_pkg::WALK_W-1:0] in_walk;
    logic [gfs_pkg::DRAW_W-1:0] in_pick;

    assign in_cidx = s_axis_tdata[11:0];
    assign in_slot = s_axis_tdata[14:12];
    assign in_var  = s_axis_tdata[24:15];
    assign in_pol  = s_axis_tdata[25];
    assign in_used = s_axis_tdata[26];
    assign in_walk = s_axis_tdata[36:27];
    assign in_pick = s_axis_tdata[68:37];

    // Control registers.
    logic [4:0]                  state_reg, state_next;
    logic [gfs_pkg::NC_W-1:0]    cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic [gfs_pkg::NV_W-1:0]    nv_cfg_reg;
    logic [gfs_pkg::NC_W-1:0]    nc_cfg_reg;
    logic [gfs_pkg::WALK_W-1:0]  thr_reg;

    // Working registers.
    logic [gfs_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic                        pass_sat_reg, pass_sat_next;
    logic                        pend_reg, pend_next;
    logic                        pend_used_reg, pend_used_next;
    logic                        pend_pol_reg, pend_pol_next;
    logic                        csat_reg, csat_next;
    logic [gfs_pkg::VAR_W-1:0]   scan_var_reg, scan_var_next;
    logic [gfs_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [gfs_pkg::CIDX_W-1:0]  ld_cidx_reg, ld_cidx_next;
    logic [gfs_pkg::SLOT_W-1:0]  ld_slot_reg, ld_slot_next;
    logic [gfs_pkg::LIT_W-1:0]   ld_lit_reg, ld_lit_next;
    logic [gfs_pkg::DRAW_W-1:0]  pick_reg, pick_next;

    // Result registers; best_reg is the running best gain.
    logic [gfs_pkg::VAR_W-1:0]   flip_reg, flip_next;
    logic [gfs_pkg::GAIN_W-1:0]  best_reg, best_next;
    logic [gfs_pkg::NV_W-1:0]    ties_reg, ties_next;
    logic                        walk_reg, walk_next;
    logic                        sat_reg, sat_next;

    // RAM ports.
    logic                        cl_we;
    logic [gfs_pkg::CIDX_W-1:0]  cl_waddr, cl_raddr;
    logic [gfs_pkg::ROW_W-1:0]   cl_wdata, cl_rdata;
    logic                        as_we, as_wdata, as_rdata;
    logic [gfs_pkg::VAR_W-1:0]   as_waddr, as_raddr;
    logic                        gn_we;
    logic [gfs_pkg::VAR_W-1:0]   gn_waddr, gn_raddr;
    logic [gfs_pkg::GAIN_W-1:0]  gn_wdata, gn_rdata;
    logic                        tl_we;
    logic [gfs_pkg::VAR_W-1:0]   tl_waddr, tl_raddr, tl_wdata, tl_rdata;

    gfs_pkg::div_req_t           div_req;
    logic                        div_done;
    logic [gfs_pkg::VAR_W-1:0]   div_rem;

    logic                        s_fire, m_fire;
    logic [gfs_pkg::NV_W-1:0]    nv_eff, nv_last;
    logic [gfs_pkg::NC_W-1:0]    nc_eff;
    logic [gfs_pkg::LIT_W-1:0]   cur_lit;
    logic [gfs_pkg::ROW_W-1:0]   ld_row;
    logic [gfs_pkg::MAX_CLAUSE_LENGTH-1:0] occ1;
    logic                        pend_true;
    logic                        csat_v;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // Clamp the configured counts into their legal ranges.
    always_comb begin
        if (nv_cfg_reg == '0) begin
            nv_eff = gfs_pkg::NV_W'(1);
        end else if (nv_cfg_reg > gfs_pkg::NV_W'(gfs_pkg::MAX_VARIABLES)) begin
            nv_eff = gfs_pkg::NV_W'(gfs_pkg::MAX_VARIABLES);
        end else begin
            nv_eff = nv_cfg_reg;
        end
        if (nc_cfg_reg > gfs_pkg::NC_W'(gfs_pkg::MAX_CLAUSES)) begin
            nc_eff = gfs_pkg::NC_W'(gfs_pkg::MAX_CLAUSES);
        end else begin
            nc_eff = nc_cfg_reg;
        end
    end
    assign nv_last = nv_eff - 1'b1;

    assign cur_lit = row_reg[slot_reg*gfs_pkg::LIT_W +: gfs_pkg::LIT_W];

    // A literal earns gain only if its variable appears once among the used
    // slots of the clause.
    always_comb begin
        for (int g = 0; g < gfs_pkg::MAX_CLAUSE_LENGTH; g++) begin
            occ1[g] = row_reg[g*gfs_pkg::LIT_W + gfs_pkg::LIT_USED_BIT];
            for (int t = 0; t < gfs_pkg::MAX_CLAUSE_LENGTH; t++) begin
                if (t != g && row_reg[t*gfs_pkg::LIT_W + gfs_pkg::LIT_USED_BIT] &&
                    row_reg[t*gfs_pkg::LIT_W +: gfs_pkg::VAR_W] ==
                    row_reg[g*gfs_pkg::LIT_W +: gfs_pkg::VAR_W]) begin
                    occ1[g] = 1'b0;
                end
            end
        end
    end

    // The assignment value read last cycle decides the pending literal.
    assign pend_true = pend_reg && pend_used_reg && (as_rdata == pend_pol_reg);
    assign csat_v    = csat_reg || pend_true;

    always_comb begin
        ld_row = cl_rdata;
        ld_row[ld_slot_reg*gfs_pkg::LIT_W +: gfs_pkg::LIT_W] = ld_lit_reg;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        slot_next      = slot_reg;
        pass_sat_next  = pass_sat_reg;
        pend_next      = pend_reg;
        pend_used_next = pend_used_reg;
        pend_pol_next  = pend_pol_reg;
        csat_next      = csat_reg;
        scan_var_next  = scan_var_reg;
        row_next       = row_reg;
        ld_cidx_next   = ld_cidx_reg;
        ld_slot_next   = ld_slot_reg;
        ld_lit_next    = ld_lit_reg;
        pick_next      = pick_reg;
        flip_next      = flip_reg;
        best_next      = best_reg;
        ties_next      = ties_reg;
        walk_next      = walk_reg;
        sat_next       = sat_reg;

        cl_we    = 1'b0;
        cl_waddr = ld_cidx_reg;
        cl_wdata = ld_row;
        cl_raddr = cnt_reg[gfs_pkg::CIDX_W-1:0];
        as_we    = 1'b0;
        as_waddr = flip_reg;
        as_wdata = ~as_rdata;
        as_raddr = cur_lit[gfs_pkg::VAR_W-1:0];
        gn_we    = 1'b0;
        gn_waddr = cur_lit[gfs_pkg::VAR_W-1:0];
        gn_wdata = gn_rdata + 1'b1;
        gn_raddr = cnt_reg[gfs_pkg::VAR_W-1:0];
        tl_we    = 1'b0;
        tl_waddr = '0;
        tl_wdata = scan_var_reg;
        tl_raddr = div_rem;

        div_req.start    = 1'b0;
        div_req.dividend = pick_reg;
        div_req.divisor  = ties_reg;

        if (m_fire) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                cl_we    = 1'b1;
                cl_waddr = cnt_reg[gfs_pkg::CIDX_W-1:0];
                cl_wdata = '0;
                as_we    = (cnt_reg[gfs_pkg::CIDX_W-1:gfs_pkg::VAR_W] == '0);
                as_waddr = cnt_reg[gfs_pkg::VAR_W-1:0];
                as_wdata = 1'b0;
                if (cnt_reg[gfs_pkg::CIDX_W-1:0] == '1) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                cl_raddr = in_cidx;
                if (s_fire) begin
                    ld_cidx_next = in_cidx;
                    ld_slot_next = in_slot;
                    ld_lit_next  = {in_used, in_pol, in_var};
                    pick_next    = in_pick;
                    flip_next    = '0;
                    best_next    = '0;
                    ties_next    = '0;
                    walk_next    = 1'b0;
                    sat_next     = 1'b0;
                    unique case (s_axis_tuser)
                        gfs_pkg::MODE_LOAD: begin
                            state_next = ST_LD_WR;
                        end
                        gfs_pkg::MODE_SET: begin
                            as_we      = 1'b1;
                            as_waddr   = in_var;
                            as_wdata   = in_pol;
                            state_next = ST_DONE;
                        end
                        gfs_pkg::MODE_STEP: begin
                            if (in_walk < thr_reg) begin
                                walk_next        = 1'b1;
                                div_req.start    = 1'b1;
                                div_req.dividend = in_pick;
                                div_req.divisor  = nv_eff;
                                state_next       = ST_DIV_WAIT;
                            end else begin
                                cnt_next   = '0;
                                state_next = ST_GCLR;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LD_WR: begin
                cl_we      = 1'b1;
                state_next = ST_DONE;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (walk_reg) begin
                        flip_next  = div_rem;
                        state_next = ST_FLIP_RD;
                    end else begin
                        state_next = ST_TIE_WAIT;
                    end
                end
            end
            ST_TIE_WAIT: begin
                flip_next  = tl_rdata;
                state_next = ST_FLIP_RD;
            end
            ST_GCLR: begin
                gn_we    = 1'b1;
                gn_waddr = cnt_reg[gfs_pkg::VAR_W-1:0];
                gn_wdata = '0;
                if (cnt_reg == {2'b00, nv_last}) begin
                    cnt_next      = '0;
                    pass_sat_next = 1'b0;
                    state_next    = ST_ROW;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROW: begin
                if (cnt_reg >= nc_eff) begin
                    cnt_next = '0;
                    if (pass_sat_reg) begin
                        sat_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end else begin
                    state_next = ST_ROWW;
                end
            end
            ST_ROWW: begin
                row_next   = cl_rdata;
                slot_next  = '0;
                csat_next  = 1'b0;
                pend_next  = 1'b0;
                state_next = ST_LIT;
            end
            ST_LIT: begin
                pend_next      = 1'b1;
                pend_used_next = cur_lit[gfs_pkg::LIT_USED_BIT];
                pend_pol_next  = cur_lit[gfs_pkg::LIT_POL_BIT];
                csat_next      = csat_v;
                slot_next      = slot_reg + 1'b1;
                if (slot_reg == '1) begin
                    state_next = ST_LIT_END;
                end
            end
            ST_LIT_END: begin
                slot_next = '0;
                if (pass_sat_reg) begin
                    if (!csat_v) begin
                        sat_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_ROW;
                    end
                end else if (csat_v) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_ROW;
                end else begin
                    state_next = ST_GRD;
                end
            end
            ST_GRD: begin
                gn_raddr = cur_lit[gfs_pkg::VAR_W-1:0];
                if (occ1[slot_reg]) begin
                    state_next = ST_GWR;
                end else if (slot_reg == '1) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_ROW;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_GWR: begin
                // A variable that earns gain appears in no other used slot of the clause,
                // so no later gain write in this clause depends on the entry written here.
                gn_we     = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == '1) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_ROW;
                end else begin
                    state_next = ST_GRD;
                end
            end
            ST_SCAN, ST_SCAN_END: begin
                if (state_reg == ST_SCAN) begin
                    pend_next     = 1'b1;
                    scan_var_next = cnt_reg[gfs_pkg::VAR_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == {2'b00, nv_last}) begin
                        state_next = ST_SCAN_END;
                    end
                end else begin
                    state_next = ST_TIE_DIV;
                end
                // Gain of the variable read in the previous cycle.
                if (pend_reg) begin
                    if (scan_var_reg == '0 || gn_rdata > best_reg) begin
                        best_next = gn_rdata;
                        ties_next = gfs_pkg::NV_W'(1);
                        tl_we     = 1'b1;
                        tl_waddr  = '0;
                    end else if (gn_rdata == best_reg) begin
                        ties_next = ties_reg + 1'b1;
                        tl_we     = 1'b1;
                        tl_waddr  = ties_reg[gfs_pkg::VAR_W-1:0];
                    end
                end
            end
            ST_TIE_DIV: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_FLIP_RD: begin
                as_raddr   = flip_reg;
                state_next = ST_FLIP_WR;
            end
            ST_FLIP_WR: begin
                as_we         = 1'b1;
                cnt_next      = '0;
                pass_sat_next = 1'b1;
                state_next    = ST_ROW;
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            nv_cfg_reg  <= gfs_pkg::NUM_VARIABLES_RST;
            nc_cfg_reg  <= gfs_pkg::NUM_CLAUSES_RST;
            thr_reg     <= gfs_pkg::WALK_THRESHOLD_RST;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                unique case (cfg_index)
                    gfs_pkg::CFG_NUM_VARIABLES:  nv_cfg_reg <= cfg_wdata[gfs_pkg::NV_W-1:0];
                    gfs_pkg::CFG_NUM_CLAUSES:    nc_cfg_reg <= cfg_wdata;
                    gfs_pkg::CFG_WALK_THRESHOLD: thr_reg <= cfg_wdata[gfs_pkg::WALK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        pass_sat_reg  <= pass_sat_next;
        pend_reg      <= pend_next;
        pend_used_reg <= pend_used_next;
        pend_pol_reg  <= pend_pol_next;
        csat_reg      <= csat_next;
        scan_var_reg  <= scan_var_next;
        row_reg       <= row_next;
        ld_cidx_reg   <= ld_cidx_next;
        ld_slot_reg   <= ld_slot_next;
        ld_lit_reg    <= ld_lit_next;
        pick_reg      <= pick_next;
        flip_reg      <= flip_next;
        best_reg      <= best_next;
        ties_reg      <= ties_next;
        walk_reg      <= walk_next;
        sat_reg       <= sat_next;
    end

    // Clause store: one row of eight literals per clause.
    gfs_ram #(.WIDTH(gfs_pkg::ROW_W), .DEPTH(gfs_pkg::MAX_CLAUSES)) u_clause_ram (
        .aclk(aclk), .wr_en(cl_we), .wr_addr(cl_waddr), .wr_data(cl_wdata),
        .rd_addr(cl_raddr), .rd_data(cl_rdata)
    );

    gfs_ram #(.WIDTH(1), .DEPTH(gfs_pkg::MAX_VARIABLES)) u_assign_ram (
        .aclk(aclk), .wr_en(as_we), .wr_addr(as_waddr), .wr_data(as_wdata),
        .rd_addr(as_raddr), .rd_data(as_rdata)
    );

    gfs_ram #(.WIDTH(gfs_pkg::GAIN_W), .DEPTH(gfs_pkg::MAX_VARIABLES)) u_gain_ram (
        .aclk(aclk), .wr_en(gn_we), .wr_addr(gn_waddr), .wr_data(gn_wdata),
        .rd_addr(gn_raddr), .rd_data(gn_rdata)
    );

    gfs_ram #(.WIDTH(gfs_pkg::VAR_W), .DEPTH(gfs_pkg::MAX_VARIABLES)) u_tie_ram (
        .aclk(aclk), .wr_en(tl_we), .wr_addr(tl_waddr), .wr_data(tl_wdata),
        .rd_addr(tl_raddr), .rd_data(tl_rdata)
    );

    gfs_mod_unit u_mod (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .done(div_done), .rem(div_rem)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b00000, sat_reg, ties_reg, best_reg, flip_reg};
    assign m_axis_tuser  = walk_reg;

endmodule

@@ rtl/gfs_checker.sv @@
// ----------------------------------------------------------------------------
// GSAT flip selector checker
// Port-level properties of the flip selector, bound to the top level.
// ----------------------------------------------------------------------------
module gfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wen,
    input logic [1:0]  cfg_index,
    input logic [12:0] cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A held result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only one item is in flight: no input is taken while a result waits.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    // A random walk reports neither a best gain nor a tie count.
    a_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[33:10] == 24'd0)
        else $error("random walk with gain or ties");

    // A result without a walk and without ties comes from a load, a set or an unused mode.
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser && m_axis_tdata[33:23] == 11'd0
        |-> m_axis_tdata[34:0] == 35'd0)
        else $error("load result not all zero");

endmodule

bind gsat_flip_selector gfs_checker u_gfs_checker (.*);
